// File: rtl/spn16_pkg.sv
// Shared types, constants and byte functions of the SPN-16 counter-mode cipher.
package spn16_pkg;

    // Request codes carried on the req_type field
    localparam logic REQ_SBOX_WR = 1'b0;
    localparam logic REQ_DATA    = 1'b1;

    // Configuration register indexes
    localparam logic CFG_KEY   = 1'b0;
    localparam logic CFG_NONCE = 1'b1;

    // Round-key derivation constants
    localparam logic [7:0] KEY_C1 = 8'h80;
    localparam logic [7:0] KEY_C2 = 8'h30;

    // Output bit i takes input bit BIT_ORDER[i]
    localparam logic [2:0] BIT_ORDER [8] = '{3'd4, 3'd1, 3'd7, 3'd0, 3'd6, 3'd2, 3'd5, 3'd3};

    // Access to the S-box memory for one cycle
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [7:0] raddr_a;
        logic [7:0] raddr_b;
    } t_mem_req;

    function automatic logic [7:0] nibble_swap(input logic [7:0] x);
        nibble_swap = {x[3:0], x[7:4]};
    endfunction

    function automatic logic [7:0] bit_shuffle(input logic [7:0] x);
        logic [7:0] y;
        y = '0;
        for (int i = 0; i < 8; i++) begin
            y[i] = x[BIT_ORDER[i]];
        end
        bit_shuffle = y;
    endfunction

endpackage

// File: rtl/spn16_sbox_ram.sv
// S-box memory: 256 x 8, one write port and two registered read ports.
module spn16_sbox_ram (
    input  logic                i_clk,
    input  spn16_pkg::t_mem_req i_req,
    output logic [7:0]          o_rd_a,
    output logic [7:0]          o_rd_b
);

    logic [7:0] r_mem [256];
    logic [7:0] r_rd_a;
    logic [7:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        // read data holds while no read is issued
        if (i_req.re) begin
            r_rd_a <= r_mem[i_req.raddr_a];
            r_rd_b <= r_mem[i_req.raddr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

// File: rtl/spn16_round_eng.sv
// Round sequencer: key derivation, three SPN rounds, counter and output register.
module spn16_round_eng (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_cipher_key,
    input  logic [7:0]          i_nonce_byte,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_req_type,
    input  logic [7:0]          i_sbox_index,
    input  logic [7:0]          i_sbox_value,
    input  logic [7:0]          i_data_high,
    input  logic [7:0]          i_data_low,
    input  logic                i_low_present,
    input  logic                i_message_start,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_result_high,
    output logic [7:0]          o_result_low,
    output logic                o_result_low_valid,
    output spn16_pkg::t_mem_req o_mem_req,
    input  logic [7:0]          i_rd_a,
    input  logic [7:0]          i_rd_b
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KEY1 = 3'd1;
    localparam logic [2:0] ST_KEY2 = 3'd2;
    localparam logic [2:0] ST_RND1 = 3'd3;
    localparam logic [2:0] ST_RND2 = 3'd4;
    localparam logic [2:0] ST_RND3 = 3'd5;

    logic [2:0] r_step, n_step;
    logic [7:0] r_ctr;
    logic [7:0] r_hi, n_hi;
    logic [7:0] r_lo, n_lo;
    logic [7:0] r_w2, r_w3, r_w4, r_w5;
    logic [7:0] r_dh, r_dl;
    logic       r_lp;
    logic       r_out_valid;
    logic [7:0] r_res_high, r_res_low;
    logic       r_res_lv;

    logic       in_acc, data_acc, wr_acc, out_free, out_load;
    logic [7:0] ctr_used, perm_a, perm_b, w2_c, w3_c, w4_c, w5_c;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_step == ST_IDLE) || ((r_step == ST_RND3) && out_free);
    assign in_acc     = i_in_valid && o_in_ready;
    assign data_acc   = in_acc && (i_req_type == spn16_pkg::REQ_DATA);
    assign wr_acc     = in_acc && (i_req_type == spn16_pkg::REQ_SBOX_WR);

    assign ctr_used = i_message_start ? 8'd0 : r_ctr;
    assign perm_a   = spn16_pkg::bit_shuffle(i_rd_a);
    assign perm_b   = spn16_pkg::bit_shuffle(i_rd_b);
    assign w2_c     = i_cipher_key[15:8] ^ spn16_pkg::KEY_C1 ^ i_rd_a;
    assign w3_c     = w2_c ^ i_cipher_key[7:0];
    assign w4_c     = r_w2 ^ spn16_pkg::KEY_C2 ^ i_rd_a;
    assign w5_c     = w4_c ^ r_w3;

    always_comb begin
        n_step            = r_step;
        n_hi              = r_hi;
        n_lo              = r_lo;
        out_load          = 1'b0;
        o_mem_req.we      = wr_acc;
        o_mem_req.waddr   = i_sbox_index;
        o_mem_req.wdata   = i_sbox_value;
        o_mem_req.re      = data_acc;
        o_mem_req.raddr_a = spn16_pkg::nibble_swap(i_cipher_key[7:0]);
        o_mem_req.raddr_b = '0;
        unique case (r_step)
            ST_IDLE: begin
                n_step = data_acc ? ST_KEY1 : ST_IDLE;
            end
            ST_KEY1: begin
                o_mem_req.re      = 1'b1;
                o_mem_req.raddr_a = spn16_pkg::nibble_swap(w3_c);
                n_step            = ST_KEY2;
            end
            ST_KEY2: begin
                o_mem_req.re      = 1'b1;
                o_mem_req.raddr_a = r_hi;
                o_mem_req.raddr_b = r_lo;
                n_step            = ST_RND1;
            end
            ST_RND1: begin
                n_hi              = perm_a ^ r_w2;
                n_lo              = perm_b ^ r_w3;
                o_mem_req.re      = 1'b1;
                o_mem_req.raddr_a = n_hi;
                o_mem_req.raddr_b = n_lo;
                n_step            = ST_RND2;
            end
            ST_RND2: begin
                n_hi              = perm_a ^ r_w4;
                n_lo              = perm_b ^ r_w5;
                o_mem_req.re      = 1'b1;
                o_mem_req.raddr_a = n_hi;
                o_mem_req.raddr_b = n_lo;
                n_step            = ST_RND3;
            end
            ST_RND3: begin
                // hold the final read data until the output register frees up
                if (out_free) begin
                    out_load = 1'b1;
                    n_step   = data_acc ? ST_KEY1 : ST_IDLE;
                end
            end
            default: begin
                n_step = ST_IDLE;
            end
        endcase
        // first round key is the cipher key itself
        if (data_acc) begin
            n_hi = i_nonce_byte ^ i_cipher_key[15:8];
            n_lo = ctr_used ^ i_cipher_key[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_ctr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (data_acc) begin
                r_ctr <= ctr_used + 8'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_lo <= n_lo;
        if (r_step == ST_KEY1) begin
            r_w2 <= w2_c;
            r_w3 <= w3_c;
        end
        if (r_step == ST_KEY2) begin
            r_w4 <= w4_c;
            r_w5 <= w5_c;
        end
        if (data_acc) begin
            r_dh <= i_data_high;
            r_dl <= i_data_low;
            r_lp <= i_low_present;
        end
        if (out_load) begin
            r_res_high <= r_dh ^ perm_a;
            r_res_low  <= r_lp ? (r_dl ^ perm_b) : 8'd0;
            r_res_lv   <= r_lp;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_result_high      = r_res_high;
    assign o_result_low       = r_res_low;
    assign o_result_low_valid = r_res_lv;

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == ST_KEY1) || (r_step == ST_KEY2) || (r_step == ST_RND1) ||
         (r_step == ST_RND2)) |-> !o_in_ready)
        else $error("input taken while rounds are in progress");

    a_data_starts_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        data_acc |=> (r_step == ST_KEY1))
        else $error("data item did not start key derivation");

    a_write_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_acc |=> (r_step == ST_IDLE))
        else $error("S-box write started the round sequence");

    a_result_from_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_step) == ST_RND3))
        else $error("result appeared outside the last round");

    a_no_write_during_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_req.we && o_mem_req.re))
        else $error("S-box write overlaps a table read");

endmodule

// File: rtl/spn16_ctr_stream_cipher_core.sv
// Top level of the SPN-16 counter-mode stream cipher: config registers and memory.
//
// A data item (a byte pair) steps through KEY1, KEY2, RND1, RND2 and RND3 from
// acceptance until its result enters the output register once that is free; a new
// item is taken in the cycle that result is loaded, so items never share a round. The
// pace is set by five dependent registered reads of the single S-box memory (two
// for round-key derivation, one per round for both bytes over its two read ports).
// An S-box write is accepted only between data items. The finished result waits
// in an output register, so the next item is accepted while it is still unread.
module spn16_ctr_stream_cipher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_sbox_index,
    input  logic [7:0]  i_sbox_value,
    input  logic [7:0]  i_data_high,
    input  logic [7:0]  i_data_low,
    input  logic        i_low_present,
    input  logic        i_message_start,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_result_high,
    output logic [7:0]  o_result_low,
    output logic        o_result_low_valid
);

    logic [15:0]         r_cipher_key;
    logic [7:0]          r_nonce_byte;
    spn16_pkg::t_mem_req mem_req;
    logic [7:0]          rd_a, rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cipher_key <= '0;
            r_nonce_byte <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                spn16_pkg::CFG_KEY:   r_cipher_key <= i_cfg_data;
                spn16_pkg::CFG_NONCE: r_nonce_byte <= i_cfg_data[7:0];
                default:              r_cipher_key <= r_cipher_key;
            endcase
        end
    end

    spn16_round_eng u_eng (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cipher_key       (r_cipher_key),
        .i_nonce_byte       (r_nonce_byte),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_sbox_index       (i_sbox_index),
        .i_sbox_value       (i_sbox_value),
        .i_data_high        (i_data_high),
        .i_data_low         (i_data_low),
        .i_low_present      (i_low_present),
        .i_message_start    (i_message_start),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_result_high      (o_result_high),
        .o_result_low       (o_result_low),
        .o_result_low_valid (o_result_low_valid),
        .o_mem_req          (mem_req),
        .i_rd_a             (rd_a),
        .i_rd_b             (rd_b)
    );

    spn16_sbox_ram u_sbox (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rd_a (rd_a),
        .o_rd_b (rd_b)
    );

endmodule
